// ===== src/detection_row_decoder_core_macros.svh =====
// assertion helpers for the detection row decoder checker
`ifndef DETECTION_ROW_DECODER_CORE_MACROS_SVH
`define DETECTION_ROW_DECODER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/drd_pkg.sv =====
package drd_pkg;

    localparam int CLASS_COUNT  = 80;
    localparam int NETWORK_SIZE = 640;
    localparam int BOX_VALUES   = 4;
    localparam int MIN_SIDE     = 10;

    localparam int VALUE_W     = 24;
    localparam int FRAME_W     = 13;
    localparam int CONF_W      = 16;
    localparam int COORD_W     = 12;
    localparam int CLASS_IDX_W = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int FRAME_MAX    = 4096;
    localparam int FRAME_RESET  = 640;
    localparam int THRESH_RESET = 19661;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CONF_THRESHOLD = 2'd2;

    // row element positions
    localparam int POS_TOTAL = BOX_VALUES + CLASS_COUNT;
    localparam int POS_W     = $clog2(POS_TOTAL + 1);
    localparam int EL_CX     = 0;
    localparam int EL_CY     = 1;
    localparam int EL_W      = 2;
    localparam int EL_H      = 3;
    localparam int CLS_W     = ($clog2(CLASS_COUNT) > CLASS_IDX_W) ?
                               $clog2(CLASS_COUNT) : CLASS_IDX_W;

    localparam logic signed [VALUE_W-1:0] LOGIT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // sigmoid table lookup
    localparam int SIG_FRAC_W = 11;
    localparam int SIG_IDX_W  = 4;
    localparam int SIG_PROD_W = CONF_W + SIG_FRAC_W;
    localparam int SIG_ROUND  = 1024;
    localparam logic [CONF_W-1:0] SIG_SAT = 16'd65514;

    // box scaling: value * frame / (NETWORK_SIZE * 4096), split into 2^k * odd
    localparam int NUM_W = VALUE_W + 2;
    localparam int FWS_W = FRAME_W + 1;
    localparam int PL_W  = NUM_W + FWS_W;
    localparam int PW_W  = VALUE_W + FWS_W;
    localparam int MAG_W = 37;

    function automatic int trailing_zeros(longint n);
        longint m;
        int k;
        m = n;
        k = 0;
        for (int i = 0; i < 62; i++)
        begin
            if (m != 0 && m[0] == 1'b0)
            begin
                m = m >>> 1;
                k = k + 1;
            end
        end
        return k;
    endfunction

    localparam longint SCALE_DIV   = longint'(NETWORK_SIZE) * 4096;
    localparam int     DIV_SHIFT   = trailing_zeros(SCALE_DIV);
    localparam longint DIV_ODD     = SCALE_DIV >>> DIV_SHIFT;
    localparam int     QN_W        = MAG_W - DIV_SHIFT;
    localparam int     ODD_LOG     = $clog2(DIV_ODD);
    localparam int     RECIP_SHIFT = QN_W + ODD_LOG;
    localparam longint RECIP       = ((longint'(1) <<< RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
    localparam int     RECIP_W     = $clog2(RECIP + 1);
    localparam int     PRODQ_W     = QN_W + RECIP_W;
    localparam int     CMP_W       = (QN_W > FRAME_W) ? QN_W : FRAME_W;

    // result packing
    localparam int IN_TDATA_W     = ((VALUE_W + 7) / 8) * 8;
    localparam int OUT_CLS_LSB    = 0;
    localparam int OUT_CONF_LSB   = OUT_CLS_LSB + CLASS_IDX_W;
    localparam int OUT_LEFT_LSB   = OUT_CONF_LSB + CONF_W;
    localparam int OUT_TOP_LSB    = OUT_LEFT_LSB + COORD_W;
    localparam int OUT_WIDTH_LSB  = OUT_TOP_LSB + COORD_W;
    localparam int OUT_HEIGHT_LSB = OUT_WIDTH_LSB + FRAME_W;
    localparam int OUT_FIELDS_W   = OUT_HEIGHT_LSB + FRAME_W;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_FIELDS_W;

    typedef struct packed {
        logic signed [VALUE_W-1:0] cx;
        logic signed [VALUE_W-1:0] cy;
        logic signed [VALUE_W-1:0] rw;
        logic signed [VALUE_W-1:0] rh;
        logic signed [VALUE_W-1:0] logit;
        logic [CLS_W-1:0]          cls;
        logic                      has_logit;
    } row_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [CONF_W-1:0] conf;
        logic              pass;
    } score_t;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [QN_W-1:0]    wq;
        logic [QN_W-1:0]    hq;
    } box_t;

    function automatic logic [CONF_W-1:0] sig_entry(logic [SIG_IDX_W:0] idx);
        logic [CONF_W-1:0] s;
        case (idx)
            5'd0:    s = 16'd32768;
            5'd1:    s = 16'd40793;
            5'd2:    s = 16'd47911;
            5'd3:    s = 16'd53581;
            5'd4:    s = 16'd57724;
            5'd5:    s = 16'd60565;
            5'd6:    s = 16'd62428;
            5'd7:    s = 16'd63615;
            5'd8:    s = 16'd64357;
            5'd9:    s = 16'd64816;
            5'd10:   s = 16'd65097;
            5'd11:   s = 16'd65269;
            5'd12:   s = 16'd65374;
            5'd13:   s = 16'd65438;
            5'd14:   s = 16'd65476;
            5'd15:   s = 16'd65500;
            default: s = SIG_SAT;
        endcase
        return s;
    endfunction

    function automatic logic [FRAME_W-1:0] frame_clamp(logic [FRAME_W-1:0] f);
        logic [FRAME_W-1:0] r;
        if (f == '0)
            r = FRAME_W'(1);
        else if (f > FRAME_W'(FRAME_MAX))
            r = FRAME_W'(FRAME_MAX);
        else
            r = f;
        return r;
    endfunction

endpackage

// ===== src/drd_row_acc.sv =====
module drd_row_acc
    import drd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] in_value,
    input  logic               in_last,
    output logic               ev_valid,
    input  logic               ev_ready,
    output row_t               ev
);

    logic                      s0_valid_reg, s0_valid_next;
    logic signed [VALUE_W-1:0] s0_value_reg;
    logic                      s0_last_reg;

    logic [POS_W-1:0]          pos_reg, pos_next;
    logic signed [VALUE_W-1:0] cx_reg, cx_next;
    logic signed [VALUE_W-1:0] cy_reg, cy_next;
    logic signed [VALUE_W-1:0] rw_reg, rw_next;
    logic signed [VALUE_W-1:0] rh_reg, rh_next;
    logic signed [VALUE_W-1:0] best_reg, best_next;
    logic [CLS_W-1:0]          cls_reg, cls_next;

    logic                      ev_valid_reg, ev_valid_next;
    row_t                      ev_reg;

    logic                      slot_free;
    logic                      consume;
    logic                      is_logit;
    logic                      take;
    logic [POS_W-1:0]          pos_inc;
    row_t                      row_n;

    always_comb
    begin
        slot_free = !ev_valid_reg || ev_ready;
        consume   = s0_valid_reg && (!s0_last_reg || slot_free);
        in_ready  = !s0_valid_reg || consume;

        is_logit = (pos_reg >= POS_W'(BOX_VALUES)) && (pos_reg < POS_W'(POS_TOTAL));
        take     = is_logit && ((pos_reg == POS_W'(BOX_VALUES)) || (s0_value_reg > best_reg));
        pos_inc  = (pos_reg < POS_W'(POS_TOTAL)) ? pos_reg + POS_W'(1) : pos_reg;

        row_n.cx        = (pos_reg == POS_W'(EL_CX)) ? s0_value_reg : cx_reg;
        row_n.cy        = (pos_reg == POS_W'(EL_CY)) ? s0_value_reg : cy_reg;
        row_n.rw        = (pos_reg == POS_W'(EL_W)) ? s0_value_reg : rw_reg;
        row_n.rh        = (pos_reg == POS_W'(EL_H)) ? s0_value_reg : rh_reg;
        row_n.logit     = take ? s0_value_reg : best_reg;
        row_n.cls       = take ? CLS_W'(pos_reg - POS_W'(BOX_VALUES)) : cls_reg;
        row_n.has_logit = pos_inc > POS_W'(BOX_VALUES);

        pos_next  = pos_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        rw_next   = rw_reg;
        rh_next   = rh_reg;
        best_next = best_reg;
        cls_next  = cls_reg;
        if (consume)
        begin
            if (s0_last_reg)
            begin
                pos_next  = '0;
                cx_next   = '0;
                cy_next   = '0;
                rw_next   = '0;
                rh_next   = '0;
                best_next = LOGIT_MIN;
                cls_next  = '0;
            end
            else
            begin
                pos_next  = pos_inc;
                cx_next   = row_n.cx;
                cy_next   = row_n.cy;
                rw_next   = row_n.rw;
                rh_next   = row_n.rh;
                best_next = row_n.logit;
                cls_next  = row_n.cls;
            end
        end

        ev_valid_next = ev_valid_reg;
        if (slot_free)
            ev_valid_next = consume && s0_last_reg;

        s0_valid_next = s0_valid_reg;
        if (in_ready)
            s0_valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            ev_valid_reg <= 1'b0;
            pos_reg      <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            rw_reg       <= '0;
            rh_reg       <= '0;
            best_reg     <= LOGIT_MIN;
            cls_reg      <= '0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            ev_valid_reg <= ev_valid_next;
            pos_reg      <= pos_next;
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            rw_reg       <= rw_next;
            rh_reg       <= rh_next;
            best_reg     <= best_next;
            cls_reg      <= cls_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s0_value_reg <= $signed(in_value);
            s0_last_reg  <= in_last;
        end
        if (slot_free && consume && s0_last_reg)
            ev_reg <= row_n;
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

endmodule

// ===== src/drd_score.sv =====
module drd_score
    import drd_pkg::*;
(
    input  logic              clk,
    input  pipe_en_t          en,
    input  row_t              ev,
    input  logic [CONF_W-1:0] threshold,
    output score_t            score
);

    // stage 2: magnitude and table reads
    logic [CONF_W-1:0]     base2_reg;
    logic [CONF_W-1:0]     diff2_reg;
    logic [SIG_FRAC_W-1:0] frac2_reg;
    logic                  sat2_reg;
    logic                  neg2_reg;
    logic [CLS_W-1:0]      cls2_reg;
    logic                  has2_reg;

    // stage 3: interpolation product
    logic [SIG_PROD_W-1:0] prod3_reg;
    logic [CONF_W-1:0]     base3_reg;
    logic                  sat3_reg;
    logic                  neg3_reg;
    logic [CLS_W-1:0]      cls3_reg;
    logic                  has3_reg;

    score_t                score_reg;

    logic                  neg;
    logic [VALUE_W-1:0]    mag;
    logic [SIG_IDX_W-1:0]  idx;
    logic [CONF_W-1:0]     lo_entry;
    logic [CONF_W-1:0]     hi_entry;
    logic [SIG_PROD_W:0]   rounded;
    logic [CONF_W:0]       s_pos;
    logic [CONF_W:0]       s_full;
    logic [CONF_W-1:0]     conf;

    always_comb
    begin
        neg      = ev.logit[VALUE_W-1];
        mag      = neg ? VALUE_W'(-ev.logit) : VALUE_W'(ev.logit);
        idx      = mag[SIG_FRAC_W +: SIG_IDX_W];
        lo_entry = sig_entry({1'b0, idx});
        hi_entry = sig_entry({1'b0, idx} + (SIG_IDX_W+1)'(1));

        rounded = (SIG_PROD_W+1)'(prod3_reg) + (SIG_PROD_W+1)'(SIG_ROUND);
        s_pos   = sat3_reg ? (CONF_W+1)'(SIG_SAT)
                           : (CONF_W+1)'(base3_reg) + (CONF_W+1)'(rounded >> SIG_FRAC_W);
        s_full  = neg3_reg ? ((CONF_W+1)'(1) << CONF_W) - s_pos : s_pos;
        conf    = CONF_W'(s_full);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            base2_reg <= lo_entry;
            diff2_reg <= hi_entry - lo_entry;
            frac2_reg <= mag[SIG_FRAC_W-1:0];
            sat2_reg  <= |mag[VALUE_W-1:SIG_FRAC_W+SIG_IDX_W];
            neg2_reg  <= neg;
            cls2_reg  <= ev.cls;
            has2_reg  <= ev.has_logit;
        end
        if (en.s3)
        begin
            prod3_reg <= diff2_reg * frac2_reg;
            base3_reg <= base2_reg;
            sat3_reg  <= sat2_reg;
            neg3_reg  <= neg2_reg;
            cls3_reg  <= cls2_reg;
            has3_reg  <= has2_reg;
        end
        if (en.s4)
        begin
            score_reg.cls  <= cls3_reg;
            score_reg.conf <= conf;
            score_reg.pass <= has3_reg && (conf > threshold);
        end
    end

    assign score = score_reg;

endmodule

// ===== src/drd_box.sv =====
module drd_box
    import drd_pkg::*;
(
    input  logic               clk,
    input  pipe_en_t           en,
    input  row_t               ev,
    input  logic [FRAME_W-1:0] frame_w,
    input  logic [FRAME_W-1:0] frame_h,
    output box_t               box
);

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    // stage 2: scaled numerators
    logic signed [PL_W-1:0] pl2_reg;
    logic signed [PL_W-1:0] pt2_reg;
    logic signed [PW_W-1:0] pw2_reg;
    logic signed [PW_W-1:0] ph2_reg;

    // stage 3: magnitudes after the power-of-two part of the divide
    logic [QN_W-1:0] ml3_reg, mt3_reg, mw3_reg, mh3_reg;
    logic            nl3_reg, nt3_reg, nw3_reg, nh3_reg;

    // stage 4: reciprocal products for the odd part of the divide
    logic [PRODQ_W-1:0] ql4_reg, qt4_reg, qw4_reg, qh4_reg;
    logic               nl4_reg, nt4_reg, nw4_reg, nh4_reg;

    box_t box_reg;

    logic signed [NUM_W-1:0] nx, ny;
    logic signed [FWS_W-1:0] fws, fhs;
    logic signed [PL_W-1:0]  pl, pt;
    logic signed [PW_W-1:0]  pw, ph;
    logic [PL_W-1:0]         abs_l, abs_t;
    logic [PW_W-1:0]         abs_w, abs_h;
    logic [QN_W-1:0]         ql, qt, qw, qh;
    logic [FRAME_W-1:0]      fw_m1, fh_m1;

    always_comb
    begin
        nx  = {ev.cx[VALUE_W-1], ev.cx, 1'b0} - {{2{ev.rw[VALUE_W-1]}}, ev.rw};
        ny  = {ev.cy[VALUE_W-1], ev.cy, 1'b0} - {{2{ev.rh[VALUE_W-1]}}, ev.rh};
        fws = $signed({1'b0, frame_w});
        fhs = $signed({1'b0, frame_h});
        pl  = nx * fws;
        pt  = ny * fhs;
        pw  = $signed(ev.rw) * fws;
        ph  = $signed(ev.rh) * fhs;

        abs_l = pl2_reg[PL_W-1] ? PL_W'(-pl2_reg) : PL_W'(pl2_reg);
        abs_t = pt2_reg[PL_W-1] ? PL_W'(-pt2_reg) : PL_W'(pt2_reg);
        abs_w = pw2_reg[PW_W-1] ? PW_W'(-pw2_reg) : PW_W'(pw2_reg);
        abs_h = ph2_reg[PW_W-1] ? PW_W'(-ph2_reg) : PW_W'(ph2_reg);

        ql = QN_W'(ql4_reg >> RECIP_SHIFT);
        qt = QN_W'(qt4_reg >> RECIP_SHIFT);
        qw = QN_W'(qw4_reg >> RECIP_SHIFT);
        qh = QN_W'(qh4_reg >> RECIP_SHIFT);

        fw_m1 = frame_w - FRAME_W'(1);
        fh_m1 = frame_h - FRAME_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            pl2_reg <= pl;
            pt2_reg <= pt;
            pw2_reg <= pw;
            ph2_reg <= ph;
        end
        if (en.s3)
        begin
            ml3_reg <= QN_W'(MAG_W'(abs_l) >> (DIV_SHIFT + 1));
            mt3_reg <= QN_W'(MAG_W'(abs_t) >> (DIV_SHIFT + 1));
            mw3_reg <= QN_W'(MAG_W'(abs_w) >> DIV_SHIFT);
            mh3_reg <= QN_W'(MAG_W'(abs_h) >> DIV_SHIFT);
            nl3_reg <= pl2_reg[PL_W-1];
            nt3_reg <= pt2_reg[PL_W-1];
            nw3_reg <= pw2_reg[PW_W-1];
            nh3_reg <= ph2_reg[PW_W-1];
        end
        if (en.s4)
        begin
            ql4_reg <= ml3_reg * RECIP_C;
            qt4_reg <= mt3_reg * RECIP_C;
            qw4_reg <= mw3_reg * RECIP_C;
            qh4_reg <= mh3_reg * RECIP_C;
            nl4_reg <= nl3_reg;
            nt4_reg <= nt3_reg;
            nw4_reg <= nw3_reg;
            nh4_reg <= nh3_reg;
        end
        if (en.s5)
        begin
            // edges: negative goes to zero, far side to frame - 1
            if (nl4_reg)
                box_reg.left <= '0;
            else if (CMP_W'(ql) > CMP_W'(fw_m1))
                box_reg.left <= COORD_W'(fw_m1);
            else
                box_reg.left <= COORD_W'(ql);
            if (nt4_reg)
                box_reg.top <= '0;
            else if (CMP_W'(qt) > CMP_W'(fh_m1))
                box_reg.top <= COORD_W'(fh_m1);
            else
                box_reg.top <= COORD_W'(qt);
            // sides: at least one pixel, upper bound applied at the output
            box_reg.wq <= (nw4_reg || qw == '0) ? QN_W'(1) : qw;
            box_reg.hq <= (nh4_reg || qh == '0) ? QN_W'(1) : qh;
        end
    end

    assign box = box_reg;

endmodule

// ===== src/detection_row_decoder_core.sv =====
// Detection row decoder. Each candidate row streams in one value per transaction: x centre,
// y centre, width, height, then one class logit per class, with tlast on the final value.
// One value is taken every cycle with no gap between rows, unless back-pressure holds a row's
// last value. Every row goes down a six-register pipeline (input, row snapshot, table read with
// the scale multiplies, interpolation multiply with the power-of-two shift, reciprocal multiply,
// edge clamp) into the output register. Rows with no logit, or that fail the confidence or
// minimum-size test, give no transaction. Back-pressure on the master side only reaches the
// slave side once every pipeline register holds a pending row. Frame size and threshold are
// written through the cfg channel, which is always ready; the user must write them only while
// no row is in flight, which the block itself does not enforce; a frame size of zero acts as
// one and one above 4096 as 4096.
module detection_row_decoder_core
    import drd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // class_index, confidence, box_left,
                                                   // box_top, box_width, box_height
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [FRAME_W-1:0] frame_w_reg;
    logic [FRAME_W-1:0] frame_h_reg;
    logic [CONF_W-1:0]  thresh_reg;

    logic     ev_valid;
    logic     ev_ready;
    row_t     ev;
    pipe_en_t en;
    score_t   score4;
    box_t     box5;

    logic   v2_reg, v3_reg, v4_reg, v5_reg;
    logic   v2_next, v3_next, v4_next, v5_next;
    logic   ready2, ready3, ready4, ready5, ready_out;
    score_t score5_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [OUT_FIELDS_W-1:0]  out_data_reg;

    logic [FRAME_W-1:0] lim_w, lim_h;
    logic [FRAME_W-1:0] side_w, side_h;
    logic               emit;

    drd_row_acc u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_value (s_axis_tdata[VALUE_W-1:0]),
        .in_last  (s_axis_tlast),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev       (ev)
    );

    drd_score u_score (
        .clk       (clk),
        .en        (en),
        .ev        (ev),
        .threshold (thresh_reg),
        .score     (score4)
    );

    drd_box u_box (
        .clk     (clk),
        .en      (en),
        .ev      (ev),
        .frame_w (frame_w_reg),
        .frame_h (frame_h_reg),
        .box     (box5)
    );

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg <= FRAME_W'(FRAME_RESET);
            frame_h_reg <= FRAME_W'(FRAME_RESET);
            thresh_reg  <= CONF_W'(THRESH_RESET);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:    frame_w_reg <= frame_clamp(cfg_data[FRAME_W-1:0]);
                REG_FRAME_HEIGHT:   frame_h_reg <= frame_clamp(cfg_data[FRAME_W-1:0]);
                REG_CONF_THRESHOLD: thresh_reg  <= cfg_data[CONF_W-1:0];
                default:            ;
            endcase
        end
    end

    // pipeline flow control
    always_comb
    begin
        ready_out = !out_valid_reg || m_axis_tready;
        ready5    = !v5_reg || ready_out;
        ready4    = !v4_reg || ready5;
        ready3    = !v3_reg || ready4;
        ready2    = !v2_reg || ready3;
        ev_ready  = ready2;

        en.s2 = ready2;
        en.s3 = ready3;
        en.s4 = ready4;
        en.s5 = ready5;

        v2_next = ready2 ? ev_valid : v2_reg;
        v3_next = ready3 ? v2_reg : v3_reg;
        v4_next = ready4 ? v3_reg : v4_reg;
        v5_next = ready5 ? v4_reg : v5_reg;
    end

    // final side clamp and minimum size test
    always_comb
    begin
        lim_w  = frame_w_reg - FRAME_W'(box5.left);
        lim_h  = frame_h_reg - FRAME_W'(box5.top);
        side_w = (CMP_W'(box5.wq) > CMP_W'(lim_w)) ? lim_w : FRAME_W'(box5.wq);
        side_h = (CMP_W'(box5.hq) > CMP_W'(lim_h)) ? lim_h : FRAME_W'(box5.hq);
        emit   = score5_reg.pass && (side_w > FRAME_W'(MIN_SIDE))
                 && (side_h > FRAME_W'(MIN_SIDE));

        out_valid_next = out_valid_reg;
        if (ready_out)
            out_valid_next = v5_reg && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            v5_reg        <= v5_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready5)
            score5_reg <= score4;
        if (ready_out && v5_reg && emit)
            out_data_reg <= {side_h, side_w, box5.top, box5.left, score5_reg.conf,
                             CLASS_IDX_W'(score5_reg.cls)};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_data_reg};

endmodule

// ===== src/drd_chk.sv =====
`include "detection_row_decoder_core_macros.svh"

module drd_chk
    import drd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [COORD_W-1:0] out_left;
    logic [COORD_W-1:0] out_top;
    logic [FRAME_W-1:0] out_width;
    logic [FRAME_W-1:0] out_height;
    logic [FRAME_W:0]   right_edge;
    logic [FRAME_W:0]   bottom_edge;
    logic               stalled;

    assign out_left    = m_axis_tdata[OUT_LEFT_LSB +: COORD_W];
    assign out_top     = m_axis_tdata[OUT_TOP_LSB +: COORD_W];
    assign out_width   = m_axis_tdata[OUT_WIDTH_LSB +: FRAME_W];
    assign out_height  = m_axis_tdata[OUT_HEIGHT_LSB +: FRAME_W];
    assign right_edge  = (FRAME_W+1)'(out_left) + (FRAME_W+1)'(out_width);
    assign bottom_edge = (FRAME_W+1)'(out_top) + (FRAME_W+1)'(out_height);
    assign stalled     = m_axis_tvalid && !m_axis_tready;

    // a waiting detection is not withdrawn
    `DRD_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid, "detection dropped while stalled")

    // every detection passed the minimum side test
    `DRD_ASSERT_NOW(a_min_side, m_axis_tvalid,
        (out_width > FRAME_W'(MIN_SIDE)) && (out_height > FRAME_W'(MIN_SIDE)),
        "detection below minimum side")

    // box stays inside the largest frame
    `DRD_ASSERT_NOW(a_right_edge, m_axis_tvalid, right_edge <= (FRAME_W+1)'(FRAME_MAX),
        "box extends past right frame edge")
    `DRD_ASSERT_NOW(a_bottom_edge, m_axis_tvalid, bottom_edge <= (FRAME_W+1)'(FRAME_MAX),
        "box extends past bottom frame edge")

endmodule

bind detection_row_decoder_core drd_chk u_drd_chk (.*);

// ===== tb/sv/detection_row_decoder_core_test.sv =====
module detection_row_decoder_core_test;
    import drd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;
    localparam int GAP_MAX      = 11;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 115;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam int CHECK_MODEL = 0;
    localparam int CHECK_HIT   = 1;
    localparam int CHECK_NONE  = 2;

    localparam int ROW_NORMAL = 0;
    localparam int ROW_FULL   = 1;
    localparam int ROW_LONG   = 2;
    localparam int ROW_SHORT  = 3;
    localparam int ROW_NOISE  = 4;

    localparam longint Q_ONE = 4096;

    typedef struct packed {
        logic [CLASS_IDX_W-1:0] cls;
        logic [CONF_W-1:0]      conf;
        logic [COORD_W-1:0]     left;
        logic [COORD_W-1:0]     top;
        logic [FRAME_W-1:0]     width;
        logic [FRAME_W-1:0]     height;
    } detection_t;

    typedef struct {
        logic signed [VALUE_W-1:0] v;
        bit                        last;
        int                        mode;
        detection_t                want;
    } stim_step_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    detection_row_decoder_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // decoder state mirrored by the predictor
    logic [FRAME_W-1:0] frame_w_reg;
    logic [FRAME_W-1:0] frame_h_reg;
    logic [CONF_W-1:0]  thresh_reg;
    int                 row_pos;
    longint             row_cx;
    longint             row_cy;
    longint             row_w;
    longint             row_h;
    longint             row_best;
    int                 row_best_cls;

    detection_t pending_detections[$];
    stim_step_t plan[$];
    int         mismatches;
    int         cycle_count;
    bit         tx_burst;
    bit         rx_burst;
    longint     last_logit;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("detection_row_decoder_core regression: fail");
            $finish;
        end
    end

    function automatic longint sig_point(int i);
        longint s;
        case (i)
            0:       s = 32768;
            1:       s = 40793;
            2:       s = 47911;
            3:       s = 53581;
            4:       s = 57724;
            5:       s = 60565;
            6:       s = 62428;
            7:       s = 63615;
            8:       s = 64357;
            9:       s = 64816;
            10:      s = 65097;
            11:      s = 65269;
            12:      s = 65374;
            13:      s = 65438;
            14:      s = 65476;
            15:      s = 65500;
            default: s = 65514;
        endcase
        return s;
    endfunction

    function automatic longint sigmoid_conf(longint x);
        longint mag;
        longint idx;
        longint frac;
        longint s;
        mag = (x < 0) ? -x : x;
        idx = mag >> 11;
        frac = mag & 2047;
        if (idx >= 16)
            s = sig_point(16);
        else
            s = sig_point(int'(idx)) +
                (((sig_point(int'(idx) + 1) - sig_point(int'(idx))) * frac + 1024) >> 11);
        return (x < 0) ? 65536 - s : s;
    endfunction

    function automatic longint clamp_range(longint x, longint lo, longint hi);
        longint r;
        r = x;
        if (r < lo)
            r = lo;
        if (r > hi)
            r = hi;
        return r;
    endfunction

    function automatic longint frame_pixels(logic [FRAME_W-1:0] f);
        longint r;
        if (f == '0)
            r = 1;
        else if (f > FRAME_MAX)
            r = FRAME_MAX;
        else
            r = longint'(f);
        return r;
    endfunction

    function automatic void clear_row();
        row_pos = 0;
        row_cx = 0;
        row_cy = 0;
        row_w = 0;
        row_h = 0;
        row_best = longint'(LOGIT_MIN);
        row_best_cls = 0;
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH:    frame_w_reg = data[FRAME_W-1:0];
            REG_FRAME_HEIGHT:   frame_h_reg = data[FRAME_W-1:0];
            REG_CONF_THRESHOLD: thresh_reg = data[CONF_W-1:0];
            default:            ;
        endcase
    endfunction

    // advances the row state by one value, returns 1 when a detection comes out
    function automatic bit decode_value(input logic signed [VALUE_W-1:0] v, input bit last,
                                        output detection_t det);
        longint x;
        longint conf;
        longint fwx;
        longint fhx;
        longint span;
        longint left;
        longint top;
        longint wd;
        longint ht;
        bit     hit;
        x = longint'(v);
        hit = 1'b0;
        det = '0;
        if (row_pos == EL_CX)
            row_cx = x;
        else if (row_pos == EL_CY)
            row_cy = x;
        else if (row_pos == EL_W)
            row_w = x;
        else if (row_pos == EL_H)
            row_h = x;
        else if (row_pos < POS_TOTAL)
        begin
            if (row_pos == BOX_VALUES || x > row_best)
            begin
                row_best = x;
                row_best_cls = row_pos - BOX_VALUES;
            end
        end
        if (row_pos < POS_TOTAL)
            row_pos++;
        if (last)
        begin
            if (row_pos > BOX_VALUES)
            begin
                conf = sigmoid_conf(row_best);
                if (conf > longint'(thresh_reg))
                begin
                    fwx = frame_pixels(frame_w_reg);
                    fhx = frame_pixels(frame_h_reg);
                    span = longint'(NETWORK_SIZE) * Q_ONE;
                    left = ((2 * row_cx - row_w) * fwx) / (2 * span);
                    top = ((2 * row_cy - row_h) * fhx) / (2 * span);
                    wd = (row_w * fwx) / span;
                    ht = (row_h * fhx) / span;
                    left = clamp_range(left, 0, fwx - 1);
                    top = clamp_range(top, 0, fhx - 1);
                    wd = clamp_range(wd, 1, fwx - left);
                    ht = clamp_range(ht, 1, fhx - top);
                    if (wd > MIN_SIDE && ht > MIN_SIDE)
                    begin
                        hit = 1'b1;
                        det.cls = row_best_cls[CLASS_IDX_W-1:0];
                        det.conf = conf[CONF_W-1:0];
                        det.left = left[COORD_W-1:0];
                        det.top = top[COORD_W-1:0];
                        det.width = wd[FRAME_W-1:0];
                        det.height = ht[FRAME_W-1:0];
                    end
                end
            end
            clear_row();
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %0s got %0d expected %0d", cycle_count, what, got, want);
        mismatches++;
    endtask

    task automatic check_detection(input logic [OUT_TDATA_W-1:0] d);
        detection_t want;
        if (pending_detections.size() == 0)
        begin
            report_mismatch("transaction with nothing pending, tdata", longint'(d[63:0]), 0);
        end
        else
        begin
            want = pending_detections.pop_front();
            if (d[OUT_CLS_LSB +: CLASS_IDX_W] != want.cls)
                report_mismatch("class_index", longint'(d[OUT_CLS_LSB +: CLASS_IDX_W]),
                                longint'(want.cls));
            if (d[OUT_CONF_LSB +: CONF_W] != want.conf)
                report_mismatch("confidence", longint'(d[OUT_CONF_LSB +: CONF_W]),
                                longint'(want.conf));
            if (d[OUT_LEFT_LSB +: COORD_W] != want.left)
                report_mismatch("box_left", longint'(d[OUT_LEFT_LSB +: COORD_W]),
                                longint'(want.left));
            if (d[OUT_TOP_LSB +: COORD_W] != want.top)
                report_mismatch("box_top", longint'(d[OUT_TOP_LSB +: COORD_W]),
                                longint'(want.top));
            if (d[OUT_WIDTH_LSB +: FRAME_W] != want.width)
                report_mismatch("box_width", longint'(d[OUT_WIDTH_LSB +: FRAME_W]),
                                longint'(want.width));
            if (d[OUT_HEIGHT_LSB +: FRAME_W] != want.height)
                report_mismatch("box_height", longint'(d[OUT_HEIGHT_LSB +: FRAME_W]),
                                longint'(want.height));
        end
    endtask

    task automatic push_value(input logic signed [VALUE_W-1:0] v, input bit last,
                              output bit hit, output detection_t det);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        hit = decode_value(v, last, det);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    // hold the stream until every pending detection is out and the pipeline is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_detections.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure_phase(input int p);
        logic [CFG_DATA_W-1:0] fw;
        logic [CFG_DATA_W-1:0] fh;
        logic [CFG_DATA_W-1:0] th;
        case (p)
            0:
            begin
                fw = 640;
                fh = 480;
                th = 19661;
            end
            1:
            begin
                fw = 1;
                fh = 4096;
                th = 0;
            end
            2:
            begin
                fw = 4096;
                fh = 1;
                th = 16'hFFFF;
            end
            3:
            begin
                fw = 0;
                fh = 16'h1FFF;
                th = 32768;
            end
            4:
            begin
                fw = 16'hFFFF;
                fh = 1080;
                th = 50000;
            end
            default:
            begin
                fw = CFG_DATA_W'($urandom_range(64, FRAME_MAX));
                fh = CFG_DATA_W'($urandom_range(64, FRAME_MAX));
                th = CFG_DATA_W'($urandom_range(0, 60000));
            end
        endcase
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_CONF_THRESHOLD, th);
        if (p % 3 == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [VALUE_W-1:0] draw_box(int pos);
        logic signed [VALUE_W-1:0] v;
        if ($urandom_range(0, 99) < 8)
            v = VALUE_W'($urandom);
        else if (pos < EL_W)
            v = VALUE_W'($urandom_range(0, 640 * Q_ONE));
        else
            v = VALUE_W'($urandom_range(0, 720 * Q_ONE));
        return v;
    endfunction

    function automatic logic signed [VALUE_W-1:0] draw_logit();
        logic signed [VALUE_W-1:0] v;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            v = VALUE_W'(longint'($urandom_range(0, 24 * Q_ONE)) - 12 * Q_ONE);
        else if (r < 70)
            v = VALUE_W'($urandom);
        else if (r < 78)
        begin
            case ($urandom_range(0, 2))
                0:       v = LOGIT_MIN;
                1:       v = {1'b0, {(VALUE_W-1){1'b1}}};
                default: v = '0;
            endcase
        end
        else
            v = VALUE_W'(last_logit);
        last_logit = longint'(v);
        return v;
    endfunction

    task automatic send_row(input int kind, output int counted);
        int                        n_vals;
        bit                        last;
        bit                        hit;
        detection_t                det;
        logic signed [VALUE_W-1:0] v;
        tx_burst = ($urandom_range(0, 3) == 0);
        case (kind)
            ROW_FULL:  n_vals = POS_TOTAL;
            ROW_LONG:  n_vals = POS_TOTAL + $urandom_range(1, 12);
            ROW_SHORT: n_vals = $urandom_range(1, BOX_VALUES);
            ROW_NOISE: n_vals = BOX_VALUES + $urandom_range(1, 12);
            default:   n_vals = BOX_VALUES + $urandom_range(1, 8);
        endcase
        for (int i = 0; i < n_vals; i++)
        begin
            last = (i == n_vals - 1);
            if (kind == ROW_NOISE)
            begin
                v = VALUE_W'($urandom);
                if ($urandom_range(0, 15) == 0)
                    last = 1'b1;
            end
            else if (i < BOX_VALUES)
                v = draw_box(i);
            else
                v = draw_logit();
            push_value(v, last, hit, det);
            if (hit)
                pending_detections.insert(pending_detections.size(), det);
        end
        counted = n_vals;
    endtask

    function automatic int pick_row_kind();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 62)
            k = ROW_NORMAL;
        else if (r < 72)
            k = ROW_FULL;
        else if (r < 78)
            k = ROW_LONG;
        else if (r < 88)
            k = ROW_SHORT;
        else
            k = ROW_NOISE;
        return k;
    endfunction

    task automatic add_step(input longint v, input bit last, input int mode,
                            input longint cls = 0, input longint conf = 0,
                            input longint left = 0, input longint top = 0,
                            input longint wd = 0, input longint ht = 0);
        stim_step_t s;
        s.v = VALUE_W'(v);
        s.last = last;
        s.mode = mode;
        s.want.cls = CLASS_IDX_W'(cls);
        s.want.conf = CONF_W'(conf);
        s.want.left = COORD_W'(left);
        s.want.top = COORD_W'(top);
        s.want.width = FRAME_W'(wd);
        s.want.height = FRAME_W'(ht);
        plan.insert(plan.size(), s);
    endtask

    // result side: random stalls, every transaction checked against the oldest prediction
    initial
    begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        rx_burst = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            check_detection(m_axis_tdata);
            if ($urandom_range(0, 7) == 0)
                rx_burst = !rx_burst;
        end
    end

    initial
    begin : stimulus
        int         items;
        int         counted;
        bit         hit;
        detection_t det;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        cycle_count = 0;
        tx_burst = 1'b0;
        last_logit = 0;
        frame_w_reg = FRAME_W'(FRAME_RESET);
        frame_h_reg = FRAME_W'(FRAME_RESET);
        thresh_reg = CONF_W'(THRESH_RESET);
        clear_row();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-frame box with saturated logit, reset settings
        add_step(320 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(320 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(640 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(640 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(8 * Q_ONE, 1'b1, CHECK_HIT, 0, 65514, 0, 0, 640, 640);
        // short rows
        add_step(100, 1'b0, CHECK_NONE);
        add_step(200, 1'b1, CHECK_NONE);
        add_step(300, 1'b1, CHECK_NONE);
        // field extremes
        add_step(longint'(LOGIT_MIN), 1'b0, CHECK_NONE);
        add_step(8388607, 1'b0, CHECK_NONE);
        add_step(8388607, 1'b0, CHECK_NONE);
        add_step(longint'(LOGIT_MIN), 1'b0, CHECK_NONE);
        add_step(longint'(LOGIT_MIN), 1'b1, CHECK_MODEL);
        // tie on the best logit, first class wins
        add_step(320 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(320 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(100 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(100 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(2 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(3 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(3 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(Q_ONE, 1'b1, CHECK_HIT, 1, 62428, 270, 270, 100, 100);
        // width of exactly ten pixels is dropped
        add_step(320 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(320 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(10 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(100 * Q_ONE, 1'b0, CHECK_NONE);
        add_step(8388607, 1'b1, CHECK_NONE);

        foreach (plan[i])
        begin
            push_value(plan[i].v, plan[i].last, hit, det);
            if (plan[i].mode == CHECK_MODEL)
            begin
                if (hit)
                    pending_detections.insert(pending_detections.size(), det);
            end
            else if (plan[i].mode == CHECK_HIT)
                pending_detections.insert(pending_detections.size(), plan[i].want);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain();
            configure_phase(p);
            items = 0;
            while (items < PHASE_ITEMS)
            begin
                send_row(pick_row_kind(), counted);
                items += counted;
            end
        end

        drain();
        if (mismatches == 0)
            $display("detection_row_decoder_core regression: pass");
        else
            $display("detection_row_decoder_core regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/drd_pkg.sv
src/drd_row_acc.sv
src/drd_score.sv
src/drd_box.sv
src/detection_row_decoder_core.sv
src/drd_chk.sv
tb/sv/detection_row_decoder_core_test.sv
